>>> rtl/psdr_pkg.sv
// Shared constants, types and codes of the point splat depth renderer.
package psdr_pkg;

    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int DEPTH_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(DEPTH_WORDS);
    localparam int DATA_W      = 32;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 9;
    localparam int POSE_WORDS  = 12;
    localparam int POSE_IDX_W  = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0] EMPTY_LIMIT = 32'd66;
    localparam logic [31:0] SPLAT_K     = 32'd246101626;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_POSE   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_POSE,
        OP_NOP,
        OP_RENDER,
        OP_READ
    } t_op;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_RANGE  = 2'd1,
        STS_BEHIND = 2'd2,
        STS_OFF    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_HEIGHT    = 3'd5,
        REG_MAX_RANGE = 3'd6
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_XF_MUL,
        S_XF_ACC,
        S_RNG,
        S_SQ_MUL,
        S_SQ_ACC,
        S_MR_MUL,
        S_SUM_CHK,
        S_PRJ_MUL,
        S_DIV_LD,
        S_DIV,
        S_PRJ_CHK,
        S_RAD,
        S_BND,
        S_BASE,
        S_SPLAT_RD,
        S_SPLAT_WR,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [31:0]      focal_x;
        logic [31:0]      focal_y;
        logic [31:0]      center_x;
        logic [31:0]      center_y;
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic [31:0]      max_range;
    } t_cfg;

    typedef struct packed {
        t_op                   op;
        logic [POSE_IDX_W-1:0] pose_index;
        logic [31:0]           pose_value;
        logic signed [31:0]    point_x;
        logic signed [31:0]    point_y;
        logic signed [31:0]    point_z;
        logic [COL_W-1:0]      pixel_col;
        logic [ROW_W-1:0]      pixel_row;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] depth;
    } t_result;

endpackage

>>> rtl/psdr_ram.sv
// Generic single-port RAM with registered read data.
module psdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/psdr_front.sv
// Front end: accepts commands, classifies them and queues them for the engine.
module psdr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_hold,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [1:0]                     i_cmd,
    input  logic [psdr_pkg::POSE_IDX_W-1:0] i_pose_index,
    input  logic signed [31:0]             i_pose_value,
    input  logic signed [31:0]             i_point_x,
    input  logic signed [31:0]             i_point_y,
    input  logic signed [31:0]             i_point_z,
    input  logic [psdr_pkg::COL_W-1:0]     i_pixel_col,
    input  logic [psdr_pkg::ROW_W-1:0]     i_pixel_row,
    output logic                           o_valid,
    output psdr_pkg::t_item                o_item,
    input  logic                           i_ready
);

    psdr_pkg::t_item                  r_mem [psdr_pkg::FIFO_DEPTH];
    logic [psdr_pkg::FIFO_PTR_W-1:0]  r_wr;
    logic [psdr_pkg::FIFO_PTR_W-1:0]  r_rd;
    logic [psdr_pkg::FIFO_PTR_W:0]    r_count;
    psdr_pkg::t_item                  item_in;
    logic                             push_ok;
    logic                             pop_ok;

    always_comb begin
        item_in.pose_index = i_pose_index;
        item_in.pose_value = i_pose_value;
        item_in.point_x    = i_point_x;
        item_in.point_y    = i_point_y;
        item_in.point_z    = i_point_z;
        item_in.pixel_col  = i_pixel_col;
        item_in.pixel_row  = i_pixel_row;
        unique case (psdr_pkg::t_cmd'(i_cmd))
            psdr_pkg::CMD_CLEAR:  item_in.op = psdr_pkg::OP_CLEAR;
            psdr_pkg::CMD_POSE: begin
                if (32'(i_pose_index) < psdr_pkg::POSE_WORDS) begin
                    item_in.op = psdr_pkg::OP_POSE;
                end else begin
                    item_in.op = psdr_pkg::OP_NOP;
                end
            end
            psdr_pkg::CMD_RENDER: item_in.op = psdr_pkg::OP_RENDER;
            psdr_pkg::CMD_READ:   item_in.op = psdr_pkg::OP_READ;
            default:              item_in.op = psdr_pkg::OP_NOP;
        endcase
    end

    assign o_full  = i_hold || (32'(r_count) == psdr_pkg::FIFO_DEPTH);
    assign push_ok = i_push && !o_full;
    assign o_valid = (r_count != '0);
    assign pop_ok  = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= item_in;
        end
    end

endmodule

>>> rtl/psdr_engine.sv
// Back end: loads the pose, clears and reads the store, and transforms, range checks, projects and splats points.
module psdr_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psdr_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  psdr_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_init_busy,
    output logic              o_res_valid,
    output psdr_pkg::t_result o_res,
    input  logic              i_res_ready
);

    localparam logic [psdr_pkg::ADDR_W-1:0] LAST_ADDR =
        psdr_pkg::ADDR_W'(psdr_pkg::DEPTH_WORDS - 1);
    localparam logic [psdr_pkg::ADDR_W-1:0] ROW_STEP =
        psdr_pkg::ADDR_W'(psdr_pkg::MAX_WIDTH);

    psdr_pkg::t_state r_state, n_state;

    logic [31:0]                  r_pose [psdr_pkg::POSE_WORDS];
    logic [31:0]                  n_pose [psdr_pkg::POSE_WORDS];
    logic signed [31:0]           r_p [3], n_p [3];
    logic signed [35:0]           r_c [3], n_c [3];
    logic [1:0]                   r_i, n_i, r_j, n_j, r_job, n_job;
    logic signed [65:0]           r_prod;
    logic [65:0]                  r_sum, n_sum;
    logic [63:0]                  r_num, n_num;
    logic [31:0]                  r_rem, n_rem;
    logic [5:0]                   r_cnt, n_cnt;
    logic [31:0]                  r_dz, n_dz;
    logic [psdr_pkg::COL_W-1:0]   r_cx, n_cx, r_x, n_x, r_x0, n_x0, r_x1, n_x1;
    logic [psdr_pkg::ROW_W-1:0]   r_cy, n_cy, r_y, n_y, r_y1, n_y1;
    logic [32:0]                  r_rad, n_rad;
    logic [psdr_pkg::ADDR_W-1:0]  r_row_base, n_row_base, r_addr, n_addr;
    psdr_pkg::t_status            r_status, n_status;
    logic [31:0]                  r_depth, n_depth;

    logic [psdr_pkg::COL_W-1:0]   w_use;
    logic [psdr_pkg::ROW_W-1:0]   h_use;
    logic [35:0]                  mag_c [3];
    logic [3:0]                   pidx;
    logic signed [32:0]           mul_a, mul_b;
    logic [32:0]                  rem_sh;
    logic                         rem_ge;
    logic                         beyond_mag;
    logic                         sum_over;
    logic                         behind;
    logic [31:0]                  prj_center;
    logic [32:0]                  prj_lim;
    logic [32:0]                  prj_pos;
    logic                         prj_off;
    logic [64:0]                  rad_sum;
    logic [psdr_pkg::COL_W-1:0]   x_room;
    logic [psdr_pkg::ROW_W-1:0]   y_room;
    logic [psdr_pkg::ADDR_W-1:0]  splat_addr;
    logic [psdr_pkg::ADDR_W-1:0]  read_addr;
    logic                         in_img;
    logic                         splat_last_col;
    logic                         splat_last;
    logic                         ram_we;
    logic [psdr_pkg::ADDR_W-1:0]  ram_addr;
    logic [31:0]                  ram_wdata;
    logic [31:0]                  ram_rdata;

    psdr_ram #(
        .WIDTH(psdr_pkg::DATA_W),
        .DEPTH(psdr_pkg::DEPTH_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign w_use = (32'(i_cfg.width) > psdr_pkg::MAX_WIDTH)
                 ? psdr_pkg::COL_W'(psdr_pkg::MAX_WIDTH) : i_cfg.width;
    assign h_use = (32'(i_cfg.height) > psdr_pkg::MAX_HEIGHT)
                 ? psdr_pkg::ROW_W'(psdr_pkg::MAX_HEIGHT) : i_cfg.height;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_c[k] = r_c[k][35] ? 36'(-r_c[k]) : 36'(r_c[k]);
        end
    end

    assign pidx = 4'(r_i) * 4'd3 + 4'(r_j);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            psdr_pkg::S_XF_MUL: begin
                mul_a = 33'(signed'(r_pose[pidx]));
                mul_b = 33'(r_p[r_j]);
            end
            psdr_pkg::S_SQ_MUL: begin
                mul_a = {1'b0, mag_c[r_i][31:0]};
                mul_b = {1'b0, mag_c[r_i][31:0]};
            end
            psdr_pkg::S_MR_MUL: begin
                mul_a = {1'b0, i_cfg.max_range};
                mul_b = {1'b0, i_cfg.max_range};
            end
            psdr_pkg::S_PRJ_MUL: begin
                priority case (r_job)
                    2'd0: begin
                        mul_a = {1'b0, mag_c[0][31:0]};
                        mul_b = {1'b0, i_cfg.focal_x};
                    end
                    2'd1: begin
                        mul_a = {1'b0, mag_c[1][31:0]};
                        mul_b = {1'b0, i_cfg.focal_y};
                    end
                    default: begin
                        mul_a = {1'b0, psdr_pkg::SPLAT_K};
                        mul_b = {1'b0, i_cfg.focal_x};
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign rem_sh = {r_rem, r_num[63]};
    assign rem_ge = (rem_sh >= {1'b0, r_dz});

    assign beyond_mag = (mag_c[0] > 36'(i_cfg.max_range)) ||
                        (mag_c[1] > 36'(i_cfg.max_range)) ||
                        (mag_c[2] > 36'(i_cfg.max_range));
    assign sum_over = (r_sum > {2'b00, r_prod[63:0]});
    assign behind   = r_c[2][35] || (r_c[2] == '0);

    always_comb begin
        if (r_job == 2'd0) begin
            prj_center = i_cfg.center_x;
            prj_lim    = 33'({w_use, 16'h0000});
        end else begin
            prj_center = i_cfg.center_y;
            prj_lim    = 33'({h_use, 16'h0000});
        end
        if (r_c[r_job][35]) begin
            prj_off = (r_num > 64'(prj_center));
            prj_pos = {1'b0, prj_center} - {1'b0, r_num[31:0]};
        end else begin
            prj_off = (r_num >= 64'(prj_lim));
            prj_pos = {1'b0, prj_center} + 33'(r_num[25:0]);
        end
        if (prj_pos >= prj_lim) begin
            prj_off = 1'b1;
        end
    end

    assign rad_sum    = {1'b0, r_num} + 65'h0_8000_0000;
    assign x_room     = w_use - 1'b1 - r_cx;
    assign y_room     = h_use - 1'b1 - r_cy;
    assign splat_addr = r_row_base + psdr_pkg::ADDR_W'(r_x);
    assign read_addr  = psdr_pkg::ADDR_W'(r_cy) * ROW_STEP + psdr_pkg::ADDR_W'(r_cx);
    assign in_img     = (r_cx < w_use) && (r_cy < h_use);
    assign splat_last_col = (r_x == r_x1);
    assign splat_last     = splat_last_col && (r_y == r_y1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psdr_pkg::S_INIT: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = psdr_pkg::S_IDLE;
                end
            end
            psdr_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op)
                        psdr_pkg::OP_CLEAR:  n_state = psdr_pkg::S_CLR;
                        psdr_pkg::OP_RENDER: n_state = psdr_pkg::S_XF_MUL;
                        psdr_pkg::OP_READ:   n_state = psdr_pkg::S_RD_ISSUE;
                        default:             n_state = psdr_pkg::S_RESULT;
                    endcase
                end
            end
            psdr_pkg::S_CLR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = psdr_pkg::S_RESULT;
                end
            end
            psdr_pkg::S_XF_MUL: n_state = psdr_pkg::S_XF_ACC;
            psdr_pkg::S_XF_ACC: begin
                if (r_i == 2'd2 && r_j == 2'd2) begin
                    n_state = psdr_pkg::S_RNG;
                end else begin
                    n_state = psdr_pkg::S_XF_MUL;
                end
            end
            psdr_pkg::S_RNG: begin
                n_state = beyond_mag ? psdr_pkg::S_RESULT : psdr_pkg::S_SQ_MUL;
            end
            psdr_pkg::S_SQ_MUL: n_state = psdr_pkg::S_SQ_ACC;
            psdr_pkg::S_SQ_ACC: begin
                n_state = (r_i == 2'd2) ? psdr_pkg::S_MR_MUL : psdr_pkg::S_SQ_MUL;
            end
            psdr_pkg::S_MR_MUL: n_state = psdr_pkg::S_SUM_CHK;
            psdr_pkg::S_SUM_CHK: begin
                n_state = (sum_over || behind) ? psdr_pkg::S_RESULT : psdr_pkg::S_PRJ_MUL;
            end
            psdr_pkg::S_PRJ_MUL: n_state = psdr_pkg::S_DIV_LD;
            psdr_pkg::S_DIV_LD:  n_state = psdr_pkg::S_DIV;
            psdr_pkg::S_DIV: begin
                if (r_cnt == 6'd63) begin
                    n_state = (r_job == 2'd2) ? psdr_pkg::S_RAD : psdr_pkg::S_PRJ_CHK;
                end
            end
            psdr_pkg::S_PRJ_CHK: begin
                n_state = prj_off ? psdr_pkg::S_RESULT : psdr_pkg::S_PRJ_MUL;
            end
            psdr_pkg::S_RAD:      n_state = psdr_pkg::S_BND;
            psdr_pkg::S_BND:      n_state = psdr_pkg::S_BASE;
            psdr_pkg::S_BASE:     n_state = psdr_pkg::S_SPLAT_RD;
            psdr_pkg::S_SPLAT_RD: n_state = psdr_pkg::S_SPLAT_WR;
            psdr_pkg::S_SPLAT_WR: begin
                n_state = splat_last ? psdr_pkg::S_RESULT : psdr_pkg::S_SPLAT_RD;
            end
            psdr_pkg::S_RD_ISSUE: begin
                n_state = in_img ? psdr_pkg::S_RD_WAIT : psdr_pkg::S_RESULT;
            end
            psdr_pkg::S_RD_WAIT: n_state = psdr_pkg::S_RESULT;
            psdr_pkg::S_RESULT: begin
                if (i_res_ready) begin
                    n_state = psdr_pkg::S_IDLE;
                end
            end
            default: n_state = psdr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pose     = r_pose;
        n_p        = r_p;
        n_c        = r_c;
        n_i        = r_i;
        n_j        = r_j;
        n_job      = r_job;
        n_sum      = r_sum;
        n_num      = r_num;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_dz       = r_dz;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_x        = r_x;
        n_x0       = r_x0;
        n_x1       = r_x1;
        n_y        = r_y;
        n_y1       = r_y1;
        n_rad      = r_rad;
        n_row_base = r_row_base;
        n_addr     = r_addr;
        n_status   = r_status;
        n_depth    = r_depth;
        ram_we     = 1'b0;
        ram_addr   = splat_addr;
        ram_wdata  = r_dz;
        o_ready    = 1'b0;
        unique case (r_state)
            psdr_pkg::S_INIT, psdr_pkg::S_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = '0;
                n_addr    = r_addr + 1'b1;
            end
            psdr_pkg::S_IDLE: begin
                o_ready  = 1'b1;
                n_status = psdr_pkg::STS_OK;
                n_depth  = '0;
                n_addr   = '0;
                n_i      = '0;
                n_j      = '0;
                n_job    = '0;
                n_p[0]   = i_item.point_x;
                n_p[1]   = i_item.point_y;
                n_p[2]   = i_item.point_z;
                for (int k = 0; k < 3; k++) begin
                    n_c[k] = 36'(signed'(r_pose[9 + k]));
                end
                n_cx     = i_item.pixel_col;
                n_cy     = i_item.pixel_row;
                if (i_valid && i_item.op == psdr_pkg::OP_POSE) begin
                    n_pose[i_item.pose_index] = i_item.pose_value;
                end
            end
            psdr_pkg::S_XF_ACC: begin
                n_c[r_i] = r_c[r_i] + 36'(r_prod >>> 30);
                if (r_j == 2'd2) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            psdr_pkg::S_RNG: begin
                n_i   = '0;
                n_sum = '0;
                if (beyond_mag) begin
                    n_status = psdr_pkg::STS_RANGE;
                end
            end
            psdr_pkg::S_SQ_ACC: begin
                n_sum = r_sum + {2'b00, r_prod[63:0]};
                n_i   = r_i + 1'b1;
            end
            psdr_pkg::S_SUM_CHK: begin
                n_dz = r_c[2][31:0];
                if (sum_over) begin
                    n_status = psdr_pkg::STS_RANGE;
                end else if (behind) begin
                    n_status = psdr_pkg::STS_BEHIND;
                end
            end
            psdr_pkg::S_DIV_LD: begin
                n_num = r_prod[63:0];
                n_rem = '0;
                n_cnt = '0;
            end
            psdr_pkg::S_DIV: begin
                n_rem = rem_ge ? 32'(rem_sh - {1'b0, r_dz}) : rem_sh[31:0];
                n_num = {r_num[62:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
            end
            psdr_pkg::S_PRJ_CHK: begin
                n_job = r_job + 1'b1;
                if (prj_off) begin
                    n_status = psdr_pkg::STS_OFF;
                end else if (r_job == 2'd0) begin
                    n_cx = prj_pos[16 +: psdr_pkg::COL_W];
                end else begin
                    n_cy = prj_pos[16 +: psdr_pkg::ROW_W];
                end
            end
            psdr_pkg::S_RAD: begin
                n_rad = rad_sum[64:32];
            end
            psdr_pkg::S_BND: begin
                n_x0 = (r_rad > 33'(r_cx)) ? '0 : r_cx - r_rad[psdr_pkg::COL_W-1:0];
                n_x  = (r_rad > 33'(r_cx)) ? '0 : r_cx - r_rad[psdr_pkg::COL_W-1:0];
                n_x1 = (r_rad >= 33'(x_room)) ? w_use - 1'b1
                                              : r_cx + r_rad[psdr_pkg::COL_W-1:0];
                n_y  = (r_rad > 33'(r_cy)) ? '0 : r_cy - r_rad[psdr_pkg::ROW_W-1:0];
                n_y1 = (r_rad >= 33'(y_room)) ? h_use - 1'b1
                                              : r_cy + r_rad[psdr_pkg::ROW_W-1:0];
            end
            psdr_pkg::S_BASE: begin
                n_row_base = psdr_pkg::ADDR_W'(r_y) * ROW_STEP;
            end
            psdr_pkg::S_SPLAT_RD: begin
                ram_addr = splat_addr;
            end
            psdr_pkg::S_SPLAT_WR: begin
                ram_addr = splat_addr;
                ram_we   = (ram_rdata < psdr_pkg::EMPTY_LIMIT) || (ram_rdata > r_dz);
                if (splat_last_col) begin
                    n_x        = r_x0;
                    n_y        = r_y + 1'b1;
                    n_row_base = r_row_base + ROW_STEP;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            psdr_pkg::S_RD_ISSUE: begin
                ram_addr = read_addr;
                if (!in_img) begin
                    n_status = psdr_pkg::STS_OFF;
                end
            end
            psdr_pkg::S_RD_WAIT: begin
                n_depth = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign o_init_busy  = (r_state == psdr_pkg::S_INIT);
    assign o_res_valid  = (r_state == psdr_pkg::S_RESULT);
    assign o_res.status = r_status;
    assign o_res.depth  = r_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psdr_pkg::S_INIT;
            r_addr  <= '0;
            for (int k = 0; k < psdr_pkg::POSE_WORDS; k++) begin
                r_pose[k] <= '0;
            end
            r_pose[0] <= psdr_pkg::ONE_Q30;
            r_pose[4] <= psdr_pkg::ONE_Q30;
            r_pose[8] <= psdr_pkg::ONE_Q30;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pose  <= n_pose;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_c        <= n_c;
        r_i        <= n_i;
        r_j        <= n_j;
        r_job      <= n_job;
        r_sum      <= n_sum;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_dz       <= n_dz;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_x        <= n_x;
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_y        <= n_y;
        r_y1       <= n_y1;
        r_rad      <= n_rad;
        r_row_base <= n_row_base;
        r_status   <= n_status;
        r_depth    <= n_depth;
    end

    a_splat_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == psdr_pkg::S_SPLAT_RD |-> 32'(splat_addr) < psdr_pkg::DEPTH_WORDS)
        else $error("splat address beyond depth store");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == psdr_pkg::S_DIV |-> r_rem < r_dz)
        else $error("divider remainder not below divisor");

    a_splat_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == psdr_pkg::S_SPLAT_WR |-> (r_x <= r_x1 && r_y <= r_y1))
        else $error("splat walk left its square");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psdr_pkg::S_RESULT && !i_res_ready)
        |=> (r_state == psdr_pkg::S_RESULT && $stable(r_status) && $stable(r_depth)))
        else $error("result dropped while output stalled");

endmodule

>>> rtl/point_splat_depth_render.sv
// Top level of the point splat depth renderer: configuration, front end, engine, result stage.
//
// Items enter through a queue interface (push, full) and results leave through
// another (empty, pop); every item gives exactly one result, in order.
// Configuration registers are written on their own valid/ready channel, which is
// always ready; write them only while no item is in flight.
// After reset the depth store is swept to empty, one word a cycle; full stays high
// during that pass. A clear item sweeps the store the same way.
// A rendered point is transformed on one shared multiplier, range checked and sent
// through three 64-step serial divisions (column, row, splat radius), then each
// pixel of the splat square takes a read-modify-write of the single-port depth store.
// A four-item queue sits in front of the engine and one result register after
// it, so items are taken while a result waits; when the receiver stalls the
// engine holds its finished result and the front queue fills up.
module point_splat_depth_render (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_cmd,
    input  logic [psdr_pkg::POSE_IDX_W-1:0]   i_pose_index,
    input  logic signed [31:0]                i_pose_value,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic signed [31:0]                i_point_z,
    input  logic [psdr_pkg::COL_W-1:0]        i_pixel_col,
    input  logic [psdr_pkg::ROW_W-1:0]        i_pixel_row,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic [31:0]                       o_depth_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [psdr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    psdr_pkg::t_cfg    r_cfg;
    psdr_pkg::t_item   q_item;
    psdr_pkg::t_result eng_res;
    psdr_pkg::t_result r_out;
    logic              r_out_valid;
    logic              q_valid;
    logic              q_ready;
    logic              init_busy;
    logic              res_valid;
    logic              res_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x   <= '0;
            r_cfg.focal_y   <= '0;
            r_cfg.center_x  <= '0;
            r_cfg.center_y  <= '0;
            r_cfg.width     <= psdr_pkg::COL_W'(640);
            r_cfg.height    <= psdr_pkg::ROW_W'(480);
            r_cfg.max_range <= 32'd327680;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (psdr_pkg::t_reg_idx'(i_cfg_index))
                psdr_pkg::REG_FOCAL_X:   r_cfg.focal_x   <= i_cfg_data;
                psdr_pkg::REG_FOCAL_Y:   r_cfg.focal_y   <= i_cfg_data;
                psdr_pkg::REG_CENTER_X:  r_cfg.center_x  <= i_cfg_data;
                psdr_pkg::REG_CENTER_Y:  r_cfg.center_y  <= i_cfg_data;
                psdr_pkg::REG_WIDTH:     r_cfg.width     <= i_cfg_data[psdr_pkg::COL_W-1:0];
                psdr_pkg::REG_HEIGHT:    r_cfg.height    <= i_cfg_data[psdr_pkg::ROW_W-1:0];
                psdr_pkg::REG_MAX_RANGE: r_cfg.max_range <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psdr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (init_busy),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_pose_index(i_pose_index),
        .i_pose_value(i_pose_value),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_ready     (q_ready)
    );

    psdr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_ready    (q_ready),
        .o_init_busy(init_busy),
        .o_res_valid(res_valid),
        .o_res      (eng_res),
        .i_res_ready(res_ready)
    );

    assign res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop && r_out_valid) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= eng_res;
        end
    end

    assign empty         = !r_out_valid;
    assign o_status      = r_out.status;
    assign o_depth_value = r_out.depth;

endmodule

>>> bench/point_splat_depth_render_test.sv
// Self-checking testbench of the point splat depth renderer with a z-buffer predictor.
`timescale 1ns / 1ps

module point_splat_depth_render_test;

    typedef struct {
        psdr_pkg::t_cmd     cmd;
        bit [3:0]           pose_index;
        bit [31:0]          pose_value;
        bit signed [31:0]   px;
        bit signed [31:0]   py;
        bit signed [31:0]   pz;
        bit [9:0]           col;
        bit [8:0]           row;
    } t_stim;

    typedef struct {
        psdr_pkg::t_status status;
        bit [31:0]         depth;
    } t_render_out;

    class t_depth_image_tracker;
        bit [31:0]   store [psdr_pkg::DEPTH_WORDS];
        bit [31:0]   pose [psdr_pkg::POSE_WORDS];
        bit [31:0]   fx, fy, cx, cy, rng;
        bit [9:0]    w;
        bit [8:0]    h;
        t_render_out pending[$];
        int          errors;

        function new();
            foreach (store[i]) store[i] = '0;
            foreach (pose[i]) pose[i] = '0;
            pose[0] = psdr_pkg::ONE_Q30;
            pose[4] = psdr_pkg::ONE_Q30;
            pose[8] = psdr_pkg::ONE_Q30;
            fx = 0;
            fy = 0;
            cx = 0;
            cy = 0;
            w = 10'd640;
            h = 9'd480;
            rng = 32'd327680;
            errors = 0;
        endfunction

        function void write_reg(psdr_pkg::t_reg_idx idx, bit [31:0] v);
            case (idx)
                psdr_pkg::REG_FOCAL_X:   fx = v;
                psdr_pkg::REG_FOCAL_Y:   fy = v;
                psdr_pkg::REG_CENTER_X:  cx = v;
                psdr_pkg::REG_CENTER_Y:  cy = v;
                psdr_pkg::REG_WIDTH:     w = v[9:0];
                psdr_pkg::REG_HEIGHT:    h = v[8:0];
                psdr_pkg::REG_MAX_RANGE: rng = v;
                default: ;
            endcase
        endfunction

        function bit project(longint num, bit [63:0] dz, bit [31:0] focal,
                             bit [31:0] center, int size, output bit [63:0] pos);
            bit [63:0] m;
            bit [63:0] q;
            bit [63:0] lim;
            m = (num < 0) ? 64'(-num) : 64'(num);
            q = m * 64'(focal) / dz;
            lim = 64'(size) << 16;
            pos = 0;
            if (num < 0) begin
                if (q > 64'(center)) return 0;
                pos = 64'(center) - q;
            end else begin
                if (q >= lim) return 0;
                pos = 64'(center) + q;
            end
            return pos < lim;
        endfunction

        function psdr_pkg::t_status render(t_stim s);
            longint    p[3];
            longint    c[3];
            bit [63:0] a[3];
            bit [63:0] sum, nsum, sq, lim, px, py, dz, r;
            longint    x0, x1, y0, y1;
            int        ew, eh;
            ew = (w > psdr_pkg::MAX_WIDTH) ? psdr_pkg::MAX_WIDTH : w;
            eh = (h > psdr_pkg::MAX_HEIGHT) ? psdr_pkg::MAX_HEIGHT : h;
            p[0] = s.px;
            p[1] = s.py;
            p[2] = s.pz;
            for (int i = 0; i < 3; i++) begin
                c[i] = longint'(signed'(pose[9 + i]));
                for (int j = 0; j < 3; j++)
                    c[i] += (longint'(signed'(pose[i * 3 + j])) * p[j]) >>> 30;
            end
            for (int i = 0; i < 3; i++) begin
                a[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
                if (a[i] > 64'(rng)) return psdr_pkg::STS_RANGE;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                sq = a[i] * a[i];
                nsum = sum + sq;
                if (nsum < sum) return psdr_pkg::STS_RANGE;
                sum = nsum;
            end
            lim = 64'(rng) * 64'(rng);
            if (sum > lim) return psdr_pkg::STS_RANGE;
            if (c[2] <= 0) return psdr_pkg::STS_BEHIND;
            dz = 64'(c[2]);
            if (!project(c[0], dz, fx, cx, ew, px)) return psdr_pkg::STS_OFF;
            if (!project(c[1], dz, fy, cy, eh, py)) return psdr_pkg::STS_OFF;
            r = ((64'(psdr_pkg::SPLAT_K) * 64'(fx)) / dz + 64'h8000_0000) >> 32;
            x0 = longint'(px >> 16) - longint'(r);
            x1 = longint'(px >> 16) + longint'(r);
            y0 = longint'(py >> 16) - longint'(r);
            y1 = longint'(py >> 16) + longint'(r);
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > ew - 1) x1 = ew - 1;
            if (y1 > eh - 1) y1 = eh - 1;
            for (longint y = y0; y <= y1; y++)
                for (longint x = x0; x <= x1; x++)
                    if (store[y * psdr_pkg::MAX_WIDTH + x] < psdr_pkg::EMPTY_LIMIT
                            || 64'(store[y * psdr_pkg::MAX_WIDTH + x]) > dz)
                        store[y * psdr_pkg::MAX_WIDTH + x] = dz[31:0];
            return psdr_pkg::STS_OK;
        endfunction

        function void accept_item(t_stim s);
            t_render_out e;
            int ew, eh;
            e.status = psdr_pkg::STS_OK;
            e.depth = 0;
            ew = (w > psdr_pkg::MAX_WIDTH) ? psdr_pkg::MAX_WIDTH : w;
            eh = (h > psdr_pkg::MAX_HEIGHT) ? psdr_pkg::MAX_HEIGHT : h;
            case (s.cmd)
                psdr_pkg::CMD_CLEAR: foreach (store[i]) store[i] = '0;
                psdr_pkg::CMD_POSE:
                    if (s.pose_index < psdr_pkg::POSE_WORDS) pose[s.pose_index] = s.pose_value;
                psdr_pkg::CMD_RENDER: e.status = render(s);
                default: begin
                    if (s.col < ew && s.row < eh)
                        e.depth = store[s.row * psdr_pkg::MAX_WIDTH + s.col];
                    else
                        e.status = psdr_pkg::STS_OFF;
                end
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(bit [1:0] st, bit [31:0] d);
            t_render_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d depth %0h", $time, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st != e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (d != e.depth) begin
                $display("%0t: depth expected %0h actual %0h", $time, e.depth, d);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_pose_index = '0;
    logic signed [31:0] i_pose_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic [9:0]  i_pixel_col = '0;
    logic [8:0]  i_pixel_row = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_depth_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    t_depth_image_tracker tracker = new();
    int send_idle = 9;
    int recv_idle = 54;

    // Camera setup used to aim well-formed points into the image.
    bit [31:0] cur_fx, cur_fy, cur_cx, cur_cy, cur_rng;
    int        cur_w, cur_h;
    int        rot_perm[3];
    int        rot_sgn[3];
    longint    trans[3];
    int        last_col, last_row;

    point_splat_depth_render dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(i_cmd), .i_pose_index(i_pose_index), .i_pose_value(i_pose_value),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_pixel_col(i_pixel_col), .i_pixel_row(i_pixel_row),
        .empty(empty), .pop(pop), .o_status(o_status), .o_depth_value(o_depth_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_result(o_status, o_depth_value);
        pop <= ($urandom_range(99) >= recv_idle);
    end

    task automatic push_item(t_stim s);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= s.cmd;
        i_pose_index <= s.pose_index;
        i_pose_value <= s.pose_value;
        i_point_x <= s.px;
        i_point_y <= s.py;
        i_point_z <= s.pz;
        i_pixel_col <= s.col;
        i_pixel_row <= s.row;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        tracker.accept_item(s);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(bit [31:0] fx, bit [31:0] fy, bit [31:0] cx,
                                bit [31:0] cy, bit [9:0] w, bit [8:0] h, bit [31:0] rng);
        bit [31:0] vals[7];
        vals = '{fx, fy, cx, cy, 32'(w), 32'(h), rng};
        for (int i = 0; i < 7; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(psdr_pkg::t_reg_idx'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
        cur_fx = fx;
        cur_fy = fy;
        cur_cx = cx;
        cur_cy = cy;
        cur_w = (w > psdr_pkg::MAX_WIDTH) ? psdr_pkg::MAX_WIDTH : w;
        cur_h = (h > psdr_pkg::MAX_HEIGHT) ? psdr_pkg::MAX_HEIGHT : h;
        cur_rng = rng;
    endtask

    function automatic t_stim mk_item(psdr_pkg::t_cmd cmd);
        t_stim s;
        s.cmd = cmd;
        s.pose_index = 4'($urandom);
        s.pose_value = $urandom;
        s.px = $urandom;
        s.py = $urandom;
        s.pz = $urandom;
        s.col = 10'($urandom);
        s.row = 9'($urandom);
        return s;
    endfunction

    function automatic t_stim mk_render(longint x, longint y, longint z);
        t_stim s;
        s = mk_item(psdr_pkg::CMD_RENDER);
        s.px = 32'(x);
        s.py = 32'(y);
        s.pz = 32'(z);
        return s;
    endfunction

    function automatic t_stim mk_read(int col, int row);
        t_stim s;
        s = mk_item(psdr_pkg::CMD_READ);
        s.col = 10'(col);
        s.row = 9'(row);
        return s;
    endfunction

    function automatic t_stim mk_pose(int idx, bit [31:0] v);
        t_stim s;
        s = mk_item(psdr_pkg::CMD_POSE);
        s.pose_index = 4'(idx);
        s.pose_value = v;
        return s;
    endfunction

    function automatic bit [31:0] rot_word(int idx);
        int i;
        int j;
        i = idx / 3;
        j = idx % 3;
        if (rot_perm[i] != j) return 32'd0;
        return (rot_sgn[i] > 0) ? psdr_pkg::ONE_Q30 : -psdr_pkg::ONE_Q30;
    endfunction

    function automatic bit [31:0] pose_word(int idx);
        if (idx < 9) return rot_word(idx);
        return 32'(trans[idx - 9]);
    endfunction

    task automatic load_pose();
        int perms[6][3];
        int k;
        perms = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
        k = $urandom_range(5);
        for (int i = 0; i < 3; i++) begin
            rot_perm[i] = perms[k][i];
            rot_sgn[i] = $urandom_range(1) ? 1 : -1;
            trans[i] = longint'($urandom_range(2 << 16)) - (1 << 16);
        end
        for (int i = 0; i < psdr_pkg::POSE_WORDS; i++)
            push_item(mk_pose(i, pose_word(i)));
    endtask

    // Picks a pixel and a depth, then maps the camera point back to the world.
    function automatic t_stim aimed_render();
        longint c[3];
        longint p[3];
        longint zhi;
        last_col = $urandom_range(cur_w - 1);
        last_row = $urandom_range(cur_h - 1);
        zhi = longint'(cur_rng) * 2 / 3;
        if (zhi < (1 << 16) + 1) zhi = (1 << 16) + 1;
        c[2] = $urandom_range(32'(zhi), 1 << 16);
        c[0] = ((longint'(last_col) << 16) + longint'($urandom_range(65535))
                - longint'(cur_cx)) * c[2] / longint'(cur_fx);
        c[1] = ((longint'(last_row) << 16) + longint'($urandom_range(65535))
                - longint'(cur_cy)) * c[2] / longint'(cur_fy);
        for (int i = 0; i < 3; i++)
            p[rot_perm[i]] = rot_sgn[i] * (c[i] - trans[i]);
        return mk_render(p[0], p[1], p[2]);
    endfunction

    task automatic random_item();
        int sel;
        int idx;
        longint z;
        sel = $urandom_range(99);
        if (sel < 42) begin
            push_item(aimed_render());
        end else if (sel < 50) begin
            z = $urandom_range(8 << 16, 1 << 15);
            if ($urandom_range(1)) z = -z;
            push_item(mk_render(longint'($urandom_range(16 << 16)) - (8 << 16),
                                longint'($urandom_range(16 << 16)) - (8 << 16), z));
        end else if (sel < 55) begin
            push_item(mk_item(psdr_pkg::CMD_RENDER));
        end else if (sel < 72) begin
            push_item(mk_read(last_col, last_row));
        end else if (sel < 86) begin
            push_item(mk_item(psdr_pkg::CMD_READ));
        end else if (sel < 92) begin
            load_pose();
        end else begin
            idx = $urandom_range(15);
            push_item(mk_pose(idx, $urandom));
            if (idx < psdr_pkg::POSE_WORDS) push_item(mk_pose(idx, pose_word(idx)));
        end
    endtask

    task automatic random_phase(int n, bit do_clear);
        int w;
        int h;
        w = $urandom_range(3) == 0 ? $urandom_range(16, 1) : $urandom_range(640, 1);
        h = $urandom_range(3) == 0 ? $urandom_range(16, 1) : $urandom_range(480, 1);
        write_config(($urandom_range(300, 20) << 16) | $urandom_range(65535),
                     ($urandom_range(300, 20) << 16) | $urandom_range(65535),
                     $urandom_range((w << 16) - 1), $urandom_range((h << 16) - 1),
                     10'(w), 9'(h), $urandom_range(12 << 16, 2 << 16));
        if (do_clear) push_item(mk_item(psdr_pkg::CMD_CLEAR));
        load_pose();
        for (int i = 0; i < n; i++) random_item();
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: identity pose, zero focal lengths, 640 x 480.
        push_item(mk_render(0, 0, 1 << 16));
        push_item(mk_read(0, 0));
        push_item(mk_read(639, 479));
        push_item(mk_read(640, 0));
        push_item(mk_read(1023, 511));
        push_item(mk_render(0, 0, -(1 << 16)));
        push_item(mk_render(0, 0, 6 << 16));
        push_item(mk_pose(15, 32'hFFFF_FFFF));
        push_item(mk_pose(11, 32'h7FFF_FFFF));
        push_item(mk_pose(11, 32'h0));
        push_item(mk_item(psdr_pkg::CMD_CLEAR));
        push_item(mk_read(0, 0));
        drain();

        write_config('1, '1, '1, '1, 10'd4, 9'd4, '1);
        push_item(mk_render(0, 0, 2 << 16));
        push_item(mk_render(0, 0, 0));
        drain();

        write_config('1, '1, 2 << 16, 2 << 16, 10'd4, 9'd4, '1);
        push_item(mk_render(0, 0, 2 << 16));
        push_item(mk_render(0, 0, 10));
        push_item(mk_read(1, 1));
        push_item(mk_render(0, 0, 1 << 16));
        push_item(mk_read(3, 3));
        for (int i = 9; i < 12; i++) push_item(mk_pose(i, 32'h8000_0000));
        push_item(mk_render(-(64'sd1 << 31) + 1, -(64'sd1 << 31) + 1, -(64'sd1 << 31) + 1));
        for (int i = 9; i < 12; i++) push_item(mk_pose(i, 32'h0));
        drain();

        write_config(0, 0, 639 << 16, 479 << 16, 10'd1023, 9'd511, 2 << 16);
        push_item(mk_render(0, 0, 1 << 16));
        push_item(mk_read(639, 479));
        drain();

        write_config(0, 0, 0, 0, 10'd0, 9'd0, 0);
        push_item(mk_render(0, 0, 0));
        push_item(mk_render(0, 0, 1));
        push_item(mk_read(0, 0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle = 9;
                recv_idle = 54;
            end else if (ph < 4) begin
                send_idle = 54;
                recv_idle = 9;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_phase(165, ph == 3);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/psdr_pkg.sv
rtl/psdr_ram.sv
rtl/psdr_front.sv
rtl/psdr_engine.sv
rtl/point_splat_depth_render.sv
bench/point_splat_depth_render_test.sv
